// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg : shared types and constants of the text console writer
// Item modes, cursor operation codes, character codes and grid defaults.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int DEF_COLUMN_COUNT = 80;
	localparam int DEF_ROW_COUNT    = 25;

	localparam logic [7:0] BLANK_CODE      = 8'd32;
	localparam logic [7:0] PRINT_LOW       = 8'd32;
	localparam logic [7:0] PRINT_HIGH      = 8'd126;
	localparam logic [7:0] NEWLINE_CODE    = 8'd10;
	localparam logic [7:0] RETURN_CODE     = 8'd13;
	localparam logic [7:0] RESET_ATTRIBUTE = 8'd7;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef logic [2:0] cur_op_t;

	localparam cur_op_t CUR_HOLD      = 3'd0;
	localparam cur_op_t CUR_HOME      = 3'd1;
	localparam cur_op_t CUR_RETURN    = 3'd2;
	localparam cur_op_t CUR_NEXT_LINE = 3'd3;
	localparam cur_op_t CUR_ADVANCE   = 3'd4;

	typedef struct packed {
		logic at_last_col;
		logic at_last_row;
	} cur_flags_t;

endpackage

// ----- design/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer : text-mode character grid with cursor
// Writes printable bytes at the cursor, handles newline, return, scroll,
// clear and cell readback over a cell memory of COLUMN_COUNT x ROW_COUNT.
// ----------------------------------------------------------------------------
// The grid lives in one cell memory (low byte character, high byte
// attribute) with one write port and one read port whose data is
// registered behind the address. The block takes one item at a time.
// A put of a printable byte, a newline, a return, an ignored byte, the
// unused mode or a read outside the grid goes from ST_EXEC to ST_DONE
// before its result is offered on m_*; a read of a cell on the grid
// passes through ST_READ between them. A clear, and any put that
// pushes the cursor past the last row, sweeps the whole memory at one
// cell per cycle; a scroll copies each cell one row up through the read
// port and blanks the bottom row in the same pass. The next item can be
// accepted in the cycle after the result has been handed to the output
// register, even while that result still waits for m_tready.
// After reset the block runs a clearing pass that fills every cell with
// a space in attribute 7; s_tready stays low until it ends, while writes
// to the default attribute register are taken at any time.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
	parameter int ROW_COUNT    = DEF_ROW_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code[7:0], char_attribute[15:8],
	                               // read_column[22:16], read_row[27:23], zero
	input  logic [1:0]  s_tuser,   // mode[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cursor_column[6:0], cursor_row[11:7],
	                               // cell_char[19:12], cell_attr[27:20],
	                               // did_scroll[28], zero
	// default attribute register
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	localparam int CELL_COUNT  = COLUMN_COUNT * ROW_COUNT;
	localparam int MOVED_COUNT = COLUMN_COUNT * (ROW_COUNT - 1);
	localparam int CW          = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
	localparam int RW          = $clog2(ROW_COUNT);
	localparam int AW          = $clog2(CELL_COUNT);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    state_d;

	// accepted item
	logic [1:0]    item_mode_q;
	logic [7:0]    item_code_q;
	logic [7:0]    item_attr_q;
	logic [6:0]    item_rcol_q;
	logic [4:0]    item_rrow_q;

	// registers
	logic [7:0]    default_attr_q;
	logic [7:0]    cur_attr_q;

	// sweep control
	logic [AW-1:0] sweep_idx_q;
	logic          sweep_scroll_q;
	logic          sweep_init_q;
	logic [7:0]    fill_attr_q;
	logic          sweep_copy;
	logic          sweep_last;

	// write pipeline of the sweep
	logic          wr_v_s1;
	logic          wr_copy_s1;
	logic [AW-1:0] wr_addr_s1;

	// cell memory
	logic [15:0]   cell_mem [CELL_COUNT];
	logic [15:0]   rd_data_q;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_we;

	// per-item decisions in ST_EXEC
	cur_op_t       cur_op;
	cur_flags_t    cur_flags;
	logic [CW-1:0] cur_col;
	logic [RW-1:0] cur_row;
	logic [AW-1:0] cur_addr;
	logic          printable;
	logic          put_write;
	logic          start_sweep;
	logic          start_scroll;
	logic          read_in_range;
	logic [AW-1:0] read_addr;
	logic [7:0]    blank_attr;

	// result
	logic [7:0]    res_char_q;
	logic [7:0]    res_attr_q;
	logic          res_scroll_q;
	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;
	logic          out_free;
	logic [15:0]   col_wide;
	logic [15:0]   row_wide;

	tcw_cursor #(
		.COLUMN_COUNT (COLUMN_COUNT),
		.ROW_COUNT    (ROW_COUNT)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (cur_op),
		.col    (cur_col),
		.row    (cur_row),
		.addr   (cur_addr),
		.flags  (cur_flags)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	assign printable     = (item_code_q >= PRINT_LOW) && (item_code_q <= PRINT_HIGH);
	assign read_in_range = (32'(item_rcol_q) < COLUMN_COUNT) && (32'(item_rrow_q) < ROW_COUNT);
	assign read_addr     = AW'(32'(item_rrow_q) * COLUMN_COUNT + 32'(item_rcol_q));
	// A printable byte sets the attribute that also blanks the incoming row.
	assign blank_attr    = (put_write) ? item_attr_q : cur_attr_q;

	// Decide what the held item does; only meaningful in ST_EXEC.
	always_comb begin
		cur_op       = CUR_HOLD;
		put_write    = 1'b0;
		start_sweep  = 1'b0;
		start_scroll = 1'b0;
		if (state_q == ST_EXEC) begin
			unique case (item_mode_q)
				MODE_PUT: begin
					if (item_code_q == NEWLINE_CODE) begin
						cur_op       = CUR_NEXT_LINE;
						start_scroll = cur_flags.at_last_row;
					end else if (item_code_q == RETURN_CODE) begin
						cur_op = CUR_RETURN;
					end else if (printable) begin
						cur_op       = CUR_ADVANCE;
						put_write    = 1'b1;
						start_scroll = cur_flags.at_last_col && cur_flags.at_last_row;
					end
				end
				MODE_CLEAR: begin
					cur_op      = CUR_HOME;
					start_sweep = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Sweep: copy from one row down while above the last row, else blank.
	assign sweep_copy = sweep_scroll_q && (32'(sweep_idx_q) < MOVED_COUNT);
	assign sweep_last = (sweep_idx_q == AW'(CELL_COUNT - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (start_sweep || start_scroll) begin
					state_d = ST_SWEEP;
				end else if (item_mode_q == MODE_READ && read_in_range) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = (sweep_init_q) ? ST_IDLE : ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_SWEEP;
			sweep_idx_q    <= '0;
			sweep_scroll_q <= 1'b0;
			sweep_init_q   <= 1'b1;
			fill_attr_q    <= RESET_ATTRIBUTE;
			default_attr_q <= RESET_ATTRIBUTE;
			cur_attr_q     <= RESET_ATTRIBUTE;
			wr_v_s1        <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				default_attr_q <= cfg_wr_data;
			end
			if (put_write) begin
				cur_attr_q <= item_attr_q;
			end
			// arm a sweep: whole grid for clear, copy plus blank for scroll
			if (state_q == ST_EXEC) begin
				sweep_idx_q    <= '0;
				sweep_scroll_q <= start_scroll;
				fill_attr_q    <= (start_scroll) ? blank_attr : default_attr_q;
			end else if (state_q == ST_SWEEP) begin
				if (sweep_last) begin
					sweep_init_q <= 1'b0;
				end else begin
					sweep_idx_q <= AW'(sweep_idx_q + 1'b1);
				end
			end
			wr_v_s1 <= (state_q == ST_SWEEP);
			// hand the result over once the output register is free
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_mode_q <= s_tuser;
			item_code_q <= s_tdata[7:0];
			item_attr_q <= s_tdata[15:8];
			item_rcol_q <= s_tdata[22:16];
			item_rrow_q <= s_tdata[27:23];
		end
		wr_copy_s1 <= sweep_copy;
		wr_addr_s1 <= sweep_idx_q;
		if (state_q == ST_EXEC) begin
			res_char_q   <= '0;
			res_attr_q   <= '0;
			res_scroll_q <= start_scroll;
		end else if (state_q == ST_READ) begin
			res_char_q <= rd_data_q[7:0];
			res_attr_q <= rd_data_q[15:8];
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {3'b000, res_scroll_q, res_attr_q, res_char_q,
			              row_wide[4:0], col_wide[6:0]};
		end
	end

	// Memory ports: the sweep write trails its read through the wr_*_s1 stage.
	always_comb begin
		mem_raddr = read_addr;
		if (state_q == ST_SWEEP) begin
			mem_raddr = (sweep_copy) ? AW'(32'(sweep_idx_q) + COLUMN_COUNT) : '0;
		end
		mem_we    = wr_v_s1 || put_write;
		mem_waddr = (wr_v_s1) ? wr_addr_s1 : cur_addr;
		if (wr_v_s1) begin
			mem_wdata = (wr_copy_s1) ? rd_data_q : {fill_attr_q, BLANK_CODE};
		end else begin
			mem_wdata = {item_attr_q, item_code_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= cell_mem[mem_raddr];
	end

	// cursor fields are cut to their port widths
	assign col_wide = 16'(cur_col);
	assign row_wide = 16'(cur_row);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- design/tcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor : cursor position of the text console writer
// Keeps column, row and linear cell address in step, so no divide is needed.
// ----------------------------------------------------------------------------
module tcw_cursor import tcw_pkg::*; #(
	parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
	parameter int ROW_COUNT    = DEF_ROW_COUNT,
	localparam int CELL_COUNT  = COLUMN_COUNT * ROW_COUNT,
	localparam int CW          = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1,
	localparam int RW          = $clog2(ROW_COUNT),
	localparam int AW          = $clog2(CELL_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cur_op_t       op,
	output logic [CW-1:0] col,
	output logic [RW-1:0] row,
	output logic [AW-1:0] addr,
	output cur_flags_t    flags
);

	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMN_COUNT - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROW_COUNT - 1);
	localparam logic [AW-1:0] LAST_BASE = AW'((ROW_COUNT - 1) * COLUMN_COUNT);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] col_d;
	logic [RW-1:0] row_d;
	logic [AW-1:0] addr_d;
	logic [AW-1:0] line_base;
	logic          line_wrap;

	assign flags.at_last_col = (col_q == LAST_COL);
	assign flags.at_last_row = (row_q == LAST_ROW);
	assign line_base = addr_q - AW'(col_q);

	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		addr_d    = addr_q;
		line_wrap = 1'b0;
		unique case (op)
			CUR_HOME: begin
				col_d  = '0;
				row_d  = '0;
				addr_d = '0;
			end
			CUR_RETURN: begin
				col_d  = '0;
				addr_d = line_base;
			end
			CUR_NEXT_LINE: begin
				line_wrap = 1'b1;
			end
			CUR_ADVANCE: begin
				if (flags.at_last_col) begin
					line_wrap = 1'b1;
				end else begin
					col_d  = CW'(col_q + 1'b1);
					addr_d = AW'(addr_q + 1'b1);
				end
			end
			default: begin
			end
		endcase
		// Go to column 0 of the next row; stay on the last row when it scrolls.
		if (line_wrap) begin
			col_d = '0;
			if (flags.at_last_row) begin
				row_d  = LAST_ROW;
				addr_d = LAST_BASE;
			end else begin
				row_d  = RW'(row_q + 1'b1);
				addr_d = AW'(line_base + AW'(COLUMN_COUNT));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			addr_q <= '0;
		end else begin
			col_q  <= col_d;
			row_q  <= row_d;
			addr_q <= addr_d;
		end
	end

	assign col  = col_q;
	assign row  = row_q;
	assign addr = addr_q;

endmodule

// ----- design/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker : port-level checks of the text console writer
// Watches both streams and the result fields over time; bound to the top.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMN_COUNT = DEF_COLUMN_COUNT,
	parameter int ROW_COUNT    = DEF_ROW_COUNT
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: no second transfer right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

	// cursor stays on the grid
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[6:0]) < COLUMN_COUNT || COLUMN_COUNT > 128)
		          && (32'(m_tdata[11:7]) < ROW_COUNT || ROW_COUNT > 32))
		else $error("cursor off the grid");

	// a scroll leaves the cursor at column 0 of the last row
	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[28] |-> m_tdata[6:0] == 7'd0
		          && 32'(m_tdata[11:7]) == ((ROW_COUNT - 1) & 31))
		else $error("scroll left cursor away from last row start");

	// a scroll result carries no cell contents
	a_scroll_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[28] |-> m_tdata[27:12] == 16'd0)
		else $error("scroll result with cell data");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMN_COUNT (COLUMN_COUNT),
	.ROW_COUNT    (ROW_COUNT)
) u_tcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/text_console_writer_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_tb : self-checking bench for the text console writer
// Drives put, clear, read and unused-mode items over the input stream with
// random gaps and back-pressure, tracks the grid, cursor and attributes in
// a shadow copy, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int COLS = DEF_COLUMN_COUNT;
	localparam int ROWS = DEF_ROW_COUNT;
	localparam int CELLS = COLS * ROWS;

	// Mode 3 is not used by the block; it must leave everything alone.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Slowest legal run: each item a full sweep plus a long receiver hold and
	// sender gaps, plus the clearing pass after reset; the watchdog limit
	// lies above that.
	localparam int CYCLE_LIMIT = 3_000_000;
	// A clear or scroll sweeps the whole grid; watch that long for stray results.
	localparam int TAIL_CYCLES = 2100;
	// Receiver hold-off used to back up the block into its input.
	localparam int HOLD_CYCLES = 400;

	// Input item as packed on s_tdata, last field in the low bits.
	typedef struct packed {
		logic [3:0] pad;
		logic [4:0] read_row;
		logic [6:0] read_col;
		logic [7:0] attr;
		logic [7:0] code;
	} console_item_t;

	// Result as packed on m_tdata[28:0], last field in the low bits.
	typedef struct packed {
		logic       did_scroll;
		logic [7:0] cell_attr;
		logic [7:0] cell_char;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
	} console_result_t;

	// ------------------------------------------------------------------------
	// Shadow console: grid, cursor and attributes, plus the results awaited
	// ------------------------------------------------------------------------
	class console_tracker;
		logic [15:0]     shadow_cells [CELLS];
		int unsigned     cursor_addr;
		logic [7:0]      print_attr;
		logic [7:0]      default_attr;
		console_result_t awaited_results [$];
		int              error_count;
		int              results_seen;

		function new();
			blank_grid(RESET_ATTRIBUTE);
			cursor_addr  = 0;
			print_attr   = RESET_ATTRIBUTE;
			default_attr = RESET_ATTRIBUTE;
			error_count  = 0;
			results_seen = 0;
		endfunction

		function void blank_grid(logic [7:0] attr);
			for (int i = 0; i < CELLS; i++)
				shadow_cells[i] = {attr, BLANK_CODE};
		endfunction

		// Move to column 0 of the row below; scroll when that row is off-grid.
		function bit next_row(int unsigned row);
			if (row + 1 >= ROWS) begin
				for (int i = 0; i < COLS * (ROWS - 1); i++)
					shadow_cells[i] = shadow_cells[i + COLS];
				for (int i = COLS * (ROWS - 1); i < CELLS; i++)
					shadow_cells[i] = {print_attr, BLANK_CODE};
				cursor_addr = (ROWS - 1) * COLS;
				return 1'b1;
			end
			cursor_addr = (row + 1) * COLS;
			return 1'b0;
		endfunction

		// Apply one accepted item and queue the result it must produce.
		function void note_item(logic [1:0] mode, console_item_t item);
			console_result_t r;
			int unsigned col, row;
			r = '0;
			col = cursor_addr % COLS;
			row = cursor_addr / COLS;
			case (mode)
				MODE_PUT: begin
					if (item.code == NEWLINE_CODE) begin
						r.did_scroll = next_row(row);
					end else if (item.code == RETURN_CODE) begin
						cursor_addr = row * COLS;
					end else if (item.code >= PRINT_LOW && item.code <= PRINT_HIGH) begin
						print_attr = item.attr;
						shadow_cells[cursor_addr] = {item.attr, item.code};
						if (col + 1 < COLS)
							cursor_addr++;
						else
							r.did_scroll = next_row(row);
					end
				end
				MODE_CLEAR: begin
					blank_grid(default_attr);
					cursor_addr = 0;
				end
				MODE_READ: begin
					if (item.read_col < COLS && item.read_row < ROWS)
						{r.cell_attr, r.cell_char} =
							shadow_cells[item.read_row * COLS + item.read_col];
				end
				default: ;
			endcase
			r.cursor_col = 7'(cursor_addr % COLS);
			r.cursor_row = 5'(cursor_addr / COLS);
			awaited_results.push_back(r);
		endfunction

		task report(string what);
			error_count++;
			$display("MISMATCH @%0t: %s", $time, what);
		endtask

		// Compare one result transfer against the oldest awaited result.
		task check_result(logic [31:0] data);
			console_result_t got, want;
			got = console_result_t'(data[28:0]);
			results_seen++;
			if (awaited_results.size() == 0) begin
				report($sformatf("result 0x%08h with nothing awaited", data));
			end else begin
				want = awaited_results.pop_front();
				if (got.cursor_col !== want.cursor_col)
					report($sformatf("cursor_column got %0d want %0d",
						got.cursor_col, want.cursor_col));
				if (got.cursor_row !== want.cursor_row)
					report($sformatf("cursor_row got %0d want %0d",
						got.cursor_row, want.cursor_row));
				if (got.cell_char !== want.cell_char)
					report($sformatf("cell_char got 0x%02h want 0x%02h",
						got.cell_char, want.cell_char));
				if (got.cell_attr !== want.cell_attr)
					report($sformatf("cell_attr got 0x%02h want 0x%02h",
						got.cell_attr, want.cell_attr));
				if (got.did_scroll !== want.did_scroll)
					report($sformatf("did_scroll got %b want %b",
						got.did_scroll, want.did_scroll));
			end
		endtask

		function int pending();
			return awaited_results.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and block
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;     // char_code, char_attribute, read_column, read_row
	logic [1:0]  s_tuser = MODE_PUT;  // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // cursor_column, cursor_row, cell_char,
	                                // cell_attr, did_scroll
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	console_tracker tracker = new();
	int             items_sent = 0;
	int             cycle_count = 0;

	text_console_writer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #10 clk = ~clk;

	// Both sides stop idling for a stretch of results.
	function bit steady_stretch();
		return tracker.results_seen >= 200 && tracker.results_seen < 260;
	endfunction

	// ------------------------------------------------------------------------
	// Driving tasks: inputs change on the falling edge
	// ------------------------------------------------------------------------

	// Offer one item, hold it until the transfer, then note it.
	task automatic send_item(logic [1:0] mode, console_item_t item);
		// Drop valid for a random gap now and then; the raise below lands on
		// a later falling edge, so valid never toggles twice in one step.
		if (!steady_stretch() && $urandom_range(99) < 8) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= item;
		do @(posedge clk); while (!s_tready);
		tracker.note_item(mode, item);
		items_sent++;
	endtask

	task automatic put_char(logic [7:0] code, logic [7:0] attr);
		console_item_t item;
		item = '0;
		item.code = code;
		item.attr = attr;
		send_item(MODE_PUT, item);
	endtask

	task automatic read_cell(int col, int row);
		console_item_t item;
		item = '0;
		item.read_col = 7'(col);
		item.read_row = 5'(row);
		send_item(MODE_READ, item);
	endtask

	task automatic clear_screen();
		console_item_t item;
		item = '0;
		send_item(MODE_CLEAR, item);
	endtask

	// Type a run of printable bytes; to_end fills the row through its last
	// column so the cursor wraps (and scrolls on the bottom row).
	task automatic type_line(bit to_end);
		int n;
		n = to_end ? COLS - (tracker.cursor_addr % COLS) : $urandom_range(1, 30);
		repeat (n) put_char(8'($urandom_range(PRINT_LOW, PRINT_HIGH)), 8'($urandom));
		case ($urandom_range(9))
			0, 1, 2, 3, 4: put_char(NEWLINE_CODE, 8'($urandom));
			5, 6:          put_char(RETURN_CODE, 8'($urandom));
			default: ;
		endcase
	endtask

	task automatic newline_run(int n);
		repeat (n) put_char(NEWLINE_CODE, 8'($urandom));
	endtask

	// Lower valid and hold off until every awaited result has come back.
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the default attribute; only called while no items are in flight.
	task automatic write_default(logic [7:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		tracker.default_attr = value;
	endtask

	// ------------------------------------------------------------------------
	// Result side: back-pressure on the falling edge, checks on the rising
	// ------------------------------------------------------------------------
	initial begin
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && tracker.results_seen >= 120) begin
				// Hold off long enough that the block backs up into its input
				// while the sender keeps offering items.
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
				m_tready <= 1'b1;
			end else if (!steady_stretch() && $urandom_range(99) < 8) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// Watchdog: end the run if the block stops making progress.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("text_console_writer_tb: errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		console_item_t item;
		logic [1:0]    mode;
		logic [7:0]    phase_attr;
		int            target;
		int            pick;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The register takes writes during the clearing pass; the grid still
		// comes up in the reset attribute.
		write_default(8'h00);

		// Directed part: reset contents, field extremes, ignored bytes,
		// cursor controls, unused mode, reads outside the grid, clear.
		read_cell(0, 0);
		read_cell(127, 31);
		read_cell(COLS - 1, ROWS - 1);
		put_char("A", 8'h00);
		put_char(PRINT_HIGH, 8'hFF);
		put_char(PRINT_LOW, 8'h5A);
		put_char(8'(PRINT_LOW - 1), 8'hFF);
		put_char(8'(PRINT_HIGH + 1), 8'hFF);
		put_char(8'h00, 8'h33);
		put_char(8'hFF, 8'hCC);
		read_cell(0, 0);
		read_cell(2, 0);
		put_char(RETURN_CODE, 8'hFF);
		put_char(NEWLINE_CODE, 8'h00);
		item = '0;
		item.code = 8'hFF;
		item.attr = 8'hFF;
		item.read_col = '1;
		item.read_row = '1;
		send_item(MODE_UNUSED, item);
		read_cell(COLS, 0);
		read_cell(0, ROWS);
		clear_screen();
		read_cell(0, 0);
		put_char("z", 8'h81);
		read_cell(0, 0);
		wait_for_results();

		// Random part in four phases, each under its own default attribute
		// and opened by a clear so the setting shows up in the grid.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       phase_attr = 8'hFF;
				1:       phase_attr = 8'($urandom);
				2:       phase_attr = 8'h00;
				default: phase_attr = RESET_ATTRIBUTE;
			endcase
			write_default(phase_attr);
			clear_screen();
			read_cell($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1));
			if (phase == 0) begin
				// Walk to the bottom row and wrap off its last column, so both
				// the newline and the printable byte paths scroll early on.
				newline_run(ROWS - 1);
				type_line(1'b1);
				newline_run(2);
			end
			target = items_sent + 30;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					type_line($urandom_range(4) == 0);
				end else if (pick < 65) begin
					// Probe mostly the cursor row, where text just went.
					repeat ($urandom_range(1, 6)) begin
						case ($urandom_range(9))
							0, 1, 2, 3, 4, 5:
								read_cell($urandom_range(0, COLS - 1),
									tracker.cursor_addr / COLS);
							6, 7:
								read_cell($urandom_range(0, COLS - 1),
									$urandom_range(0, ROWS - 1));
							default:
								read_cell($urandom_range(0, 127), $urandom_range(0, 31));
						endcase
					end
				end else if (pick < 75) begin
					newline_run($urandom_range(5, 25));
				end else if (pick < 94) begin
					// Noise: any mode, any bytes; keep full sweeps rare.
					repeat ($urandom_range(1, 4)) begin
						mode = 2'($urandom_range(0, 3));
						if (mode == MODE_CLEAR && $urandom_range(3) != 0)
							mode = MODE_UNUSED;
						item = $urandom;
						item.pad = '0;
						send_item(mode, item);
					end
				end else begin
					clear_screen();
				end
			end
			wait_for_results();
		end

		// Watch for stray results as long as one full sweep would take.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.pending()));

		if (tracker.error_count == 0)
			$display("text_console_writer_tb: clean");
		else
			$display("text_console_writer_tb: errors");
		$finish;
	end

endmodule
